### sv/hgc_pkg.sv
// ----------------------------------------------------------------------------
// hgc_pkg: shared types and constants for the height gradient colour block
// Item layouts of the input, output and configuration channels, and the job
// record that passes from the front end to the back end through the queue.
// ----------------------------------------------------------------------------
package hgc_pkg;

  // Heights are compared with 8 fraction bits; magnitudes need 25 bits.
  localparam int unsigned HFRAC = 8;
  localparam int unsigned MAG_W = 25;
  localparam int unsigned CH_W  = 8;
  localparam int unsigned NUM_CH = 3;

  typedef struct packed {
    logic signed [23:0] height_now;
    logic signed [15:0] start_height;
    logic signed [15:0] end_height;
    logic        [23:0] start_color;
    logic        [23:0] end_color;
  } in_item_t;

  typedef struct packed {
    logic [23:0] blended_color;
  } out_item_t;

  typedef struct packed {
    logic [23:0] base_color;
  } cfg_item_t;

  // One classified item: ratio operands as magnitudes and the two colours.
  typedef struct packed {
    logic [MAG_W-1:0] num_mag;
    logic [MAG_W-1:0] den_mag;
    logic             force_zero;
    logic [23:0]      color_a;
    logic [23:0]      color_b;
  } job_t;

endpackage

### sv/hgc_chan_if.sv
// ----------------------------------------------------------------------------
// hgc_chan_if: valid/ready channel
// Carries one item of type T from a source to a sink.
// ----------------------------------------------------------------------------
interface hgc_chan_if #(
  parameter type T = logic
);

  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

### sv/height_gradient_color.sv
// ----------------------------------------------------------------------------
// height_gradient_color: height driven colour blend
// Blends a 24-bit RGB colour from a current height and the end heights and
// colours of a line segment, with a configurable colour at height zero.
//
//   Channel | Direction | Item
//   --------+-----------+--------------------------------------------------
//   in_i    | sink      | height_now, start/end height, start/end colour
//   out_o   | source    | blended_color
//   cfg_i   | sink      | base_color (always ready)
//
// One item per cycle is accepted and delivered when no side stalls.
// An item passes through the queue, the entry stage, one divider stage per
// quotient bit, and the blend into the output register.
// Reset clears the queue and all stage valid bits; base_color resets to white.
// An output stall fills the back-end stages, then the two-entry queue, and
// only then drops in_i.ready.
// ----------------------------------------------------------------------------
module height_gradient_color #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  hgc_chan_if.sink   in_i,
  hgc_chan_if.source out_o,
  hgc_chan_if.sink   cfg_i
);

  logic          push;
  logic          full;
  logic          q_valid;
  logic          pop;
  hgc_pkg::job_t push_job;
  hgc_pkg::job_t head_job;

  // Front end: configuration register and classification.
  hgc_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .cfg_i  (cfg_i),
    .push_o (push),
    .job_o  (push_job),
    .full_i (full)
  );

  // Job queue between the two halves.
  hgc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (full),
    .valid_o (q_valid),
    .job_o   (head_job),
    .pop_i   (pop)
  );

  // Back end: division and blend.
  hgc_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .job_i   (head_job),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

### sv/hgc_front.sv
// ----------------------------------------------------------------------------
// hgc_front: item classification
// Holds the base colour register, picks the blend branch of each item and
// forms the ratio operands as magnitudes together with the two colours.
// ----------------------------------------------------------------------------
module hgc_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  hgc_chan_if.sink          in_i,
  hgc_chan_if.sink          cfg_i,
  output logic              push_o,
  output hgc_pkg::job_t     job_o,
  input  logic              full_i
);

  logic [23:0] base_color_q;

  logic signed [23:0] z;
  logic signed [23:0] zs;
  logic signed [23:0] ze;
  logic z_pos, z_neg, zs_pos, zs_neg, ze_pos, ze_neg;
  logic signed [hgc_pkg::MAG_W-1:0] num;
  logic signed [hgc_pkg::MAG_W-1:0] den;

  // The configuration register is always ready to be written.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_color_q <= 24'hFFFFFF;
    end else if (cfg_i.valid) begin
      base_color_q <= cfg_i.data.base_color;
    end
  end

  // An item enters whenever the queue has room.
  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;

  // Scale integer end heights to the 8 fraction bits of the current height.
  assign z  = in_i.data.height_now;
  assign zs = {in_i.data.start_height, {hgc_pkg::HFRAC{1'b0}}};
  assign ze = {in_i.data.end_height, {hgc_pkg::HFRAC{1'b0}}};

  // Strict signs: zero is neither positive nor negative.
  assign z_neg  = z[23];
  assign zs_neg = zs[23];
  assign ze_neg = ze[23];
  assign z_pos  = !z[23] && (z != '0);
  assign zs_pos = !zs[23] && (zs != '0);
  assign ze_pos = !ze[23] && (ze != '0);

  // Branch selection and ratio operands.
  always_comb begin
    num              = '0;
    den              = '0;
    job_o.force_zero = 1'b0;
    job_o.color_a    = base_color_q;
    job_o.color_b    = base_color_q;
    if ((zs_pos && ze_pos) || (zs_neg && ze_neg)) begin
      num           = {z[23], z} - {zs[23], zs};
      den           = {zs[23], zs} - {ze[23], ze};
      job_o.color_a = in_i.data.start_color;
      job_o.color_b = in_i.data.end_color;
    end else if ((z_neg && zs_neg) || (z_pos && zs_pos)) begin
      num           = {z[23], z};
      den           = {zs[23], zs};
      job_o.color_b = in_i.data.start_color;
    end else if ((z_neg && ze_neg) || (z_pos && ze_pos)) begin
      num           = {z[23], z};
      den           = {ze[23], ze};
      job_o.color_b = in_i.data.end_color;
    end else begin
      job_o.force_zero = 1'b1;
    end
    // Magnitudes of the ratio operands.
    job_o.num_mag = num[hgc_pkg::MAG_W-1] ? -num : num;
    job_o.den_mag = den[hgc_pkg::MAG_W-1] ? -den : den;
  end

endmodule

### sv/hgc_queue.sv
// ----------------------------------------------------------------------------
// hgc_queue: two-entry job queue
// Decouples the front end from the back end so that each can stall alone.
// ----------------------------------------------------------------------------
module hgc_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  hgc_pkg::job_t job_i,
  output logic          full_o,
  output logic          valid_o,
  output hgc_pkg::job_t job_o,
  input  logic          pop_i
);

  hgc_pkg::job_t entry_q [2];
  logic          wr_ptr_q;
  logic          rd_ptr_q;
  logic [1:0]    count_q;

  assign full_o  = count_q[1];
  assign valid_o = (count_q != 2'd0);
  assign job_o   = entry_q[rd_ptr_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

### sv/hgc_back.sv
// ----------------------------------------------------------------------------
// hgc_back: ratio division and colour blend
// A pipelined restoring divider yields one quotient bit per stage, then one
// stage blends the three colour channels into the output register.
// ----------------------------------------------------------------------------
module hgc_back #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  hgc_pkg::job_t job_i,
  output logic          pop_o,
  hgc_chan_if.source    out_o
);

  localparam int unsigned MW = hgc_pkg::MAG_W;
  localparam int unsigned QW = FRAC_BITS + 1;
  localparam int unsigned PW = hgc_pkg::CH_W + QW + 1;
  localparam logic [QW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  logic          valid_q [FRAC_BITS+1];
  logic [MW-1:0] rem_q   [FRAC_BITS+1];
  logic [MW-1:0] den_q   [FRAC_BITS+1];
  logic [QW-1:0] quo_q   [FRAC_BITS+1];
  logic          skip_q  [FRAC_BITS+1];
  logic [23:0]   ca_q    [FRAC_BITS+1];
  logic [23:0]   cb_q    [FRAC_BITS+1];
  logic          stg_rdy [FRAC_BITS+2];

  logic          out_valid_q;
  logic [23:0]   out_color_q;
  logic [23:0]   blend_color;
  logic          entry_zero;
  logic          entry_sat;

  // A stage takes new work when it is empty or its successor moves on.
  assign stg_rdy[FRAC_BITS+1] = !out_valid_q || out_o.ready;
  for (genvar k = 0; k <= FRAC_BITS; k++) begin : g_rdy
    assign stg_rdy[k] = !valid_q[k] || stg_rdy[k+1];
  end

  assign pop_o = valid_i && stg_rdy[0];

  // Entry: zero ratio for the base colour case and a zero divisor; a ratio of
  // one or more saturates, so only the proper fraction is divided.
  assign entry_zero = job_i.force_zero || (job_i.den_mag == '0);
  assign entry_sat  = job_i.num_mag >= job_i.den_mag;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q[0] <= 1'b0;
    end else if (stg_rdy[0]) begin
      valid_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      rem_q[0]  <= job_i.num_mag;
      den_q[0]  <= job_i.den_mag;
      skip_q[0] <= entry_zero || entry_sat;
      quo_q[0]  <= (!entry_zero && entry_sat) ? ONE : '0;
      ca_q[0]   <= job_i.color_a;
      cb_q[0]   <= job_i.color_b;
    end
  end

  // Divider stages: one quotient bit each.
  for (genvar k = 0; k < FRAC_BITS; k++) begin : g_div
    logic [MW:0]   rem2;
    logic          ge;
    logic [MW:0]   diff;

    assign rem2 = {rem_q[k], 1'b0};
    assign diff = rem2 - {1'b0, den_q[k]};
    assign ge   = !skip_q[k] && (rem2 >= {1'b0, den_q[k]});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k+1] <= 1'b0;
      end else if (stg_rdy[k+1]) begin
        valid_q[k+1] <= valid_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (stg_rdy[k+1] && valid_q[k]) begin
        rem_q[k+1]  <= ge ? diff[MW-1:0] : rem2[MW-1:0];
        den_q[k+1]  <= den_q[k];
        skip_q[k+1] <= skip_q[k];
        quo_q[k+1]  <= skip_q[k] ? quo_q[k] : {quo_q[k][QW-2:0], ge};
        ca_q[k+1]   <= ca_q[k];
        cb_q[k+1]   <= cb_q[k];
      end
    end
  end

  // Blend each channel: floor((a * (one - f) + b * f) / one).
  for (genvar c = 0; c < hgc_pkg::NUM_CH; c++) begin : g_blend
    logic [PW-1:0] mix;

    assign mix = PW'(ca_q[FRAC_BITS][c*hgc_pkg::CH_W +: hgc_pkg::CH_W]) *
                 PW'(ONE - quo_q[FRAC_BITS])
               + PW'(cb_q[FRAC_BITS][c*hgc_pkg::CH_W +: hgc_pkg::CH_W]) *
                 PW'(quo_q[FRAC_BITS]);
    assign blend_color[c*hgc_pkg::CH_W +: hgc_pkg::CH_W] =
        mix[FRAC_BITS +: hgc_pkg::CH_W];
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (stg_rdy[FRAC_BITS+1]) begin
      out_valid_q <= valid_q[FRAC_BITS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (stg_rdy[FRAC_BITS+1] && valid_q[FRAC_BITS]) begin
      out_color_q <= blend_color;
    end
  end

  assign out_o.valid              = out_valid_q;
  assign out_o.data.blended_color = out_color_q;

endmodule

### sv/hgc_checker.sv
// ----------------------------------------------------------------------------
// hgc_checker: port level checks
// Watches the channels of the top level and tracks items in flight.
// ----------------------------------------------------------------------------
module hgc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [23:0] out_color_i
);

  // Queue, entry stage, up to 24 divider stages and the output register.
  localparam int unsigned MaxInflight = 28;

  logic [5:0] inflight_q;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // Count of items accepted and not yet delivered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= 6'd0;
    end else if (in_acc && !out_acc) begin
      inflight_q <= inflight_q + 6'd1;
    end else if (out_acc && !in_acc) begin
      inflight_q <= inflight_q - 6'd1;
    end
  end

  // A shown result stays until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // A stalled result keeps its colour.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_color_i))
    else $error("result changed while stalled");

  // No result without an item in flight.
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> inflight_q != 6'd0)
    else $error("result without an accepted item");

  // The pipeline never holds more items than it has places.
  a_capacity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= 6'(MaxInflight))
    else $error("more items in flight than storage places");

endmodule

bind height_gradient_color hgc_checker u_hgc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_color_i (out_o.data.blended_color)
);

### dv/tb_height_gradient_color.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_height_gradient_color: self-checking bench for the height colour blend
// A table of directed items comes first, then random items in several phases,
// each under its own base colour. Every accepted item gets an expected colour,
// typed in or predicted in the bench, and compared with the blended colour that
// comes out, with random bursts on the input and a stall pattern on the output.
// ----------------------------------------------------------------------------
module tb_height_gradient_color;

  localparam int unsigned FRAC = 16;
  localparam int unsigned LATENCY = FRAC + 3;
  localparam longint HSCALE = 256;
  localparam int NUM_DIRECTED = 22;
  localparam int NUM_PHASES = 5;
  localparam int PHASE_ITEMS = 80;
  localparam int LONG_HOLD = 300;

  // One directed row: the item, and a typed-in colour where one is given.
  typedef struct packed {
    hgc_pkg::in_item_t item;
    logic              fixed;
    logic [23:0]       color;
  } dir_row_t;

  logic clk;
  logic rst_n;

  hgc_chan_if #(.T(hgc_pkg::in_item_t))  in_if  ();
  hgc_chan_if #(.T(hgc_pkg::out_item_t)) out_if ();
  hgc_chan_if #(.T(hgc_pkg::cfg_item_t)) cfg_if ();

  height_gradient_color #(
    .FRAC_BITS (FRAC)
  ) u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  logic [23:0] base_shadow;
  logic [23:0] color_queue [$];
  int          err_count;
  int          colors_checked;
  int          items_sent;
  int          base_writes;
  int          hold_ticket;
  int          burst_left;

  dir_row_t directed_rows [NUM_DIRECTED] = '{
    // Zero everywhere: the base colour.
    '{'{24'sd0, 16'sd0, 16'sd0, 24'h123456, 24'h654321}, 1'b1, 24'hFFFFFF},
    // Equal end heights with a shared sign give the start colour.
    '{'{24'sd1000, 16'sd5, 16'sd5, 24'h123456, 24'hABCDEF}, 1'b1, 24'h123456},
    '{'{-24'sd1000, -16'sd7, -16'sd7, 24'hFEDCBA, 24'h0F0F0F}, 1'b1, 24'hFEDCBA},
    // Ratio far above one saturates to the end colour.
    '{'{24'sd25600, 16'sd1, 16'sd2, 24'h000000, 24'hFFFFFF}, 1'b1, 24'hFFFFFF},
    // Height exactly at the start point.
    '{'{-24'sd768, -16'sd3, -16'sd10, 24'hC0FFEE, 24'h112233}, 1'b1, 24'hC0FFEE},
    // Mixed signs, height at one end: that end's colour.
    '{'{24'sd1024, 16'sd4, -16'sd9, 24'h00FF00, 24'hFF0000}, 1'b1, 24'h00FF00},
    '{'{-24'sd2304, 16'sd4, -16'sd9, 24'h00FF00, 24'hFF0000}, 1'b1, 24'hFF0000},
    // A height of zero, or no end with the height's sign, selects the base colour.
    '{'{24'sd0, 16'sd5, -16'sd5, 24'h123456, 24'h654321}, 1'b1, 24'hFFFFFF},
    '{'{24'sd500, 16'sd0, 16'sd0, 24'h123456, 24'h654321}, 1'b1, 24'hFFFFFF},
    '{'{24'sd500, -16'sd3, 16'sd0, 24'h123456, 24'h654321}, 1'b1, 24'hFFFFFF},
    // Halfway between black and white rounds down in every channel.
    '{'{24'sd512, 16'sd1, 16'sd3, 24'h000000, 24'hFFFFFF}, 1'b1, 24'h7F7F7F},
    '{'{24'sd512, 16'sd1, 16'sd3, 24'hFFFFFF, 24'h000000}, 1'b1, 24'h7F7F7F},
    // Extremes of the height fields.
    '{'{24'sh7FFFFF, 16'sh7FFF, 16'sh8000, 24'h13579B, 24'hECA864}, 1'b0, 24'h0},
    '{'{24'sh800000, 16'sh8000, 16'sh7FFF, 24'h2468AC, 24'hDB9753}, 1'b0, 24'h0},
    '{'{24'sd12345, 16'sh7FFF, 16'sh7FFF, 24'hFFFFFF, 24'h000000}, 1'b1, 24'hFFFFFF},
    '{'{-24'sd12345, 16'sh8000, 16'sh8000, 24'h000000, 24'hFFFFFF}, 1'b1, 24'h000000},
    '{'{24'sd300000, 16'sh7FFF, 16'sd1, 24'h808080, 24'h7F7F7F}, 1'b0, 24'h0},
    '{'{-24'sd4000000, 16'sh8000, -16'sd1, 24'hFF00FF, 24'h00FF00}, 1'b0, 24'h0},
    '{'{24'sd100, 16'sd7, 16'sd0, 24'h0000FF, 24'hFF0000}, 1'b0, 24'h0},
    '{'{24'sd1, 16'sh7FFF, -16'sd1, 24'hFFFFFF, 24'h000000}, 1'b0, 24'h0},
    '{'{-24'sd1, 16'sd1, 16'sh8000, 24'h555555, 24'hAAAAAA}, 1'b0, 24'h0},
    '{'{24'sd2000, 16'sd3, 16'sd9, 24'h00FF00, 24'hFF00FF}, 1'b0, 24'h0}
  };

  // Blend fraction with FRAC fraction bits, saturated at one.
  function automatic longint unsigned height_ratio(longint num, longint den);
    longint unsigned n;
    longint unsigned d;
    longint unsigned q;
    longint unsigned one;
    one = 64'd1 << FRAC;
    n = (num < 0) ? longint'(-num) : longint'(num);
    d = (den < 0) ? longint'(-den) : longint'(den);
    if (d == 0) return 64'd0;
    q = (n << FRAC) / d;
    return (q > one) ? one : q;
  endfunction

  // Per channel floor(a * (1 - f) + b * f).
  function automatic logic [23:0] mix_color(logic [23:0] ca, logic [23:0] cb,
                                            longint unsigned frac);
    longint unsigned one;
    longint unsigned a;
    longint unsigned b;
    longint unsigned ch;
    logic [23:0] res;
    one = 64'd1 << FRAC;
    for (int k = 0; k < hgc_pkg::NUM_CH; k++) begin
      a = ca[k*hgc_pkg::CH_W +: hgc_pkg::CH_W];
      b = cb[k*hgc_pkg::CH_W +: hgc_pkg::CH_W];
      ch = (a * (one - frac) + b * frac) >> FRAC;
      res[k*hgc_pkg::CH_W +: hgc_pkg::CH_W] = ch[7:0];
    end
    return res;
  endfunction

  // Expected colour of one item under the given base colour.
  function automatic logic [23:0] predict_color(hgc_pkg::in_item_t it,
                                                logic [23:0] base);
    longint z;
    longint zs;
    longint ze;
    z  = longint'($signed(it.height_now));
    zs = longint'($signed(it.start_height)) * HSCALE;
    ze = longint'($signed(it.end_height)) * HSCALE;
    if ((zs > 0 && ze > 0) || (zs < 0 && ze < 0))
      return mix_color(it.start_color, it.end_color, height_ratio(z - zs, zs - ze));
    if ((z < 0 && zs < 0) || (z > 0 && zs > 0))
      return mix_color(base, it.start_color, height_ratio(z, zs));
    if ((z < 0 && ze < 0) || (z > 0 && ze > 0))
      return mix_color(base, it.end_color, height_ratio(z, ze));
    return base;
  endfunction

  function automatic logic [23:0] pick_color();
    case ($urandom_range(0, 7))
      0:       return 24'h000000;
      1:       return 24'hFFFFFF;
      default: return 24'($urandom);
    endcase
  endfunction

  // Magnitude of an end height, weighted towards small values and extremes.
  function automatic logic signed [15:0] pick_end_mag();
    case ($urandom_range(0, 7))
      0:       return 16'sh7FFF;
      1:       return 16'sd1;
      2, 3:    return 16'($urandom_range(1, 64));
      default: return 16'($urandom_range(1, 32767));
    endcase
  endfunction

  // Mostly well-formed segments with the height in or near their span,
  // the rest noise across the whole field ranges.
  function automatic hgc_pkg::in_item_t random_item();
    hgc_pkg::in_item_t it;
    logic signed [15:0] a;
    logic signed [15:0] b;
    logic signed [15:0] t;
    longint lo;
    longint hi;
    longint zv;
    int kind;
    kind = $urandom_range(0, 9);
    it.start_color = pick_color();
    it.end_color = pick_color();
    if (kind < 5) begin
      a = pick_end_mag();
      b = pick_end_mag();
      if ($urandom_range(0, 1)) begin
        a = -a;
        b = -b;
      end
    end else if (kind < 8) begin
      a = pick_end_mag();
      b = -pick_end_mag();
      if ($urandom_range(0, 4) == 0) b = 16'sd0;
      if ($urandom_range(0, 1)) begin
        t = a;
        a = b;
        b = t;
      end
    end else begin
      a = 16'($urandom);
      b = 16'($urandom);
    end
    it.start_height = a;
    it.end_height = b;
    lo = ((a < b) ? longint'(a) : longint'(b)) * HSCALE - 512;
    hi = ((a < b) ? longint'(b) : longint'(a)) * HSCALE + 512;
    case ($urandom_range(0, 5))
      0: it.height_now = 24'($urandom);
      1: it.height_now = 24'sd0;
      default: begin
        zv = lo + longint'($urandom_range(0, 32'(hi - lo)));
        if (zv > 64'sd8388607) zv = 64'sd8388607;
        if (zv < -64'sd8388608) zv = -64'sd8388608;
        it.height_now = zv[23:0];
      end
    endcase
    return it;
  endfunction

  task automatic report_mismatch(string msg);
    if (err_count < 40) $display("MISMATCH at %0t ns: %s", $time, msg);
    err_count++;
  endtask

  // Offer one item until it is taken, then record its expected colour.
  task automatic offer_item(hgc_pkg::in_item_t it, logic fixed,
                            logic [23:0] fixed_color);
    in_if.valid <= 1'b1;
    in_if.data <= it;
    do @(posedge clk); while (!in_if.ready);
    color_queue.push_back(fixed ? fixed_color : predict_color(it, base_shadow));
    items_sent++;
  endtask

  // Bursts of random length separated by random gaps.
  task automatic pace_sender();
    burst_left--;
    if (burst_left <= 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(1, 12);
    end
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (color_queue.size() != 0) @(posedge clk);
  endtask

  task automatic write_base_color(logic [23:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.data <= value;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    base_shadow = value;
    base_writes++;
  endtask

  // Clock and reset.
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Output side: a changing stall pattern, plus a long hold-off on request.
  initial begin : output_pacer
    int mode;
    int mode_left;
    int hold_left;
    int served;
    mode = 0;
    mode_left = 0;
    hold_left = 0;
    served = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_ticket != served) begin
        served = hold_ticket;
        hold_left = LONG_HOLD;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 120);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        case (mode)
          0:       out_if.ready <= 1'b1;
          1:       out_if.ready <= ($urandom_range(0, 3) != 0);
          2:       out_if.ready <= ($urandom_range(0, 3) == 0);
          default: out_if.ready <= ((mode_left % 5) < 2);
        endcase
      end
    end
  end

  // Compare each delivered colour with the oldest expectation.
  always @(posedge clk) begin : color_check
    logic [23:0] want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (color_queue.size() == 0) begin
        report_mismatch($sformatf("colour %06h arrived with none expected",
                                  out_if.data.blended_color));
      end else begin
        want = color_queue.pop_front();
        colors_checked++;
        if (out_if.data.blended_color !== want)
          report_mismatch($sformatf("blended_color %06h, expected %06h",
                                    out_if.data.blended_color, want));
      end
    end
  end

  // Stimulus: directed table, then random phases under several base colours.
  initial begin : stimulus
    logic [23:0] phase_base [NUM_PHASES];
    phase_base = '{24'h000000, 24'hFFFFFF, 24'($urandom), 24'h00FF00, 24'($urandom)};
    err_count = 0;
    colors_checked = 0;
    items_sent = 0;
    base_writes = 0;
    burst_left = 1;
    base_shadow = 24'hFFFFFF;
    rst_n <= 1'b0;
    hold_ticket <= 0;
    in_if.valid <= 1'b0;
    in_if.data <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.data <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < NUM_DIRECTED; r++) begin
      offer_item(directed_rows[r].item, directed_rows[r].fixed, directed_rows[r].color);
      pace_sender();
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      write_base_color(phase_base[p]);
      // Hold the output off while the input keeps offering back to back.
      if (p == 2) begin
        hold_ticket <= hold_ticket + 1;
        burst_left = 60;
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 3 && i == PHASE_ITEMS / 2) wait_drained();
        offer_item(random_item(), 1'b0, 24'h0);
        pace_sender();
      end
    end

    wait_drained();
    repeat (LATENCY + 8) @(posedge clk);
    $display("Sent %0d items (%0d from the table) under %0d base colour writes.",
             items_sent, NUM_DIRECTED, base_writes);
    $display("Checked %0d colours, %0d mismatches.", colors_checked, err_count);
    if (err_count == 0) begin
      $display("height_gradient_color regression: pass");
    end else begin
      $display("height_gradient_color regression: fail");
    end
    $finish;
  end

  // Watchdog.
  initial begin : watchdog
    #2_000_000;
    $display("height_gradient_color regression: fail");
    $finish;
  end

endmodule
